### rtl/pts_pkg.sv
// Shared types and constants of the priority task scheduler.
package pts_pkg;

	localparam int ACT_W   = 3;
	localparam int ID_W    = 4;
	localparam int PRIO_W  = 3;
	localparam int DUR_W   = 20;
	localparam int STAT_W  = 2;
	localparam int COND_W  = 3;
	localparam int LVL_W   = 3;
	localparam int WAKE_W  = 32;
	localparam int STAMP_W = 16;
	localparam int SLICE_W = 8;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 8;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
	localparam int DEFAULT_LEVEL = 2;

	localparam logic [ACT_W-1:0] ACT_CREATE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_TERMINATE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TICK      = 3'd2;
	localparam logic [ACT_W-1:0] ACT_YIELD     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SLEEP     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_WAKE      = 3'd5;
	localparam logic [ACT_W-1:0] ACT_BLOCK     = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNBLOCK   = 3'd7;

	localparam logic [COND_W-1:0] C_FREE       = 3'd0;
	localparam logic [COND_W-1:0] C_READY      = 3'd1;
	localparam logic [COND_W-1:0] C_RUNNING    = 3'd2;
	localparam logic [COND_W-1:0] C_SLEEPING   = 3'd3;
	localparam logic [COND_W-1:0] C_BLOCKED    = 3'd4;
	localparam logic [COND_W-1:0] C_TERMINATED = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	localparam logic [CIDX_W-1:0] REG_SLICE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_PREEMPT = 2'd1;
	localparam logic [CIDX_W-1:0] REG_SCHED   = 2'd2;

	typedef struct packed {
		logic [COND_W-1:0]  cond;
		logic [LVL_W-1:0]   level;
		logic [WAKE_W-1:0]  wake;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic               en;
		logic [COND_W-1:0]  cond;
		logic               lvl_en;
		logic [LVL_W-1:0]   level;
		logic               stamp_en;
		logic [STAMP_W-1:0] stamp;
		logic               wake_en;
		logic [WAKE_W-1:0]  wake;
	} wreq_t;

endpackage

### rtl/pts_if.sv
// Channel interfaces of the priority task scheduler.
interface pts_in_if;
	logic                      valid;
	logic                      ready;
	logic [pts_pkg::ACT_W-1:0]  action;
	logic [pts_pkg::ID_W-1:0]   task_id;
	logic [pts_pkg::PRIO_W-1:0] priority_req;
	logic [pts_pkg::DUR_W-1:0]  duration;
	modport source(output valid, action, task_id, priority_req, duration, input ready);
	modport sink(input valid, action, task_id, priority_req, duration, output ready);
endinterface

interface pts_out_if;
	logic                      valid;
	logic                      ready;
	logic [pts_pkg::ID_W-1:0]   running_task;
	logic                      switched;
	logic [pts_pkg::STAT_W-1:0] status;
	logic [pts_pkg::ID_W-1:0]   new_task;
	modport source(output valid, running_task, switched, status, new_task, input ready);
	modport sink(input valid, running_task, switched, status, new_task, output ready);
endinterface

interface pts_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [pts_pkg::CIDX_W-1:0] index;
	logic [pts_pkg::CDAT_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/priority_task_scheduler.sv
// Top level of the priority task scheduler.
// The task table sits in a memory with one registered read port and one write port that the
// control sequencer reads one entry per cycle while it scans. A scheduling pick scans the whole
// table, and a tick wakes the due sleepers one at a time, since every wake is followed by a
// fresh scan of the table. One item is in work at a time, and its result waits in an output
// register while the next item is taken.
module priority_task_scheduler #(
	parameter int MAX_TASKS = 16,
	parameter int PRIORITY_LEVELS = 5
) (
	input logic       clk,
	input logic       arst_n,
	pts_in_if.sink    in_ch,
	pts_out_if.source out_ch,
	pts_cfg_if.sink   cfg_ch
);

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = SW + 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);
	localparam logic [pts_pkg::LVL_W-1:0] DEF_LVL =
		pts_pkg::LVL_W'((pts_pkg::DEFAULT_LEVEL < PRIORITY_LEVELS) ?
		pts_pkg::DEFAULT_LEVEL : PRIORITY_LEVELS - 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DEC      = 4'd1;
	localparam logic [3:0] S_SCHED    = 4'd2;
	localparam logic [3:0] S_SCHED_RD = 4'd3;
	localparam logic [3:0] S_PSCAN    = 4'd4;
	localparam logic [3:0] S_PEND     = 4'd5;
	localparam logic [3:0] S_WSCAN    = 4'd6;
	localparam logic [3:0] S_WEND     = 4'd7;
	localparam logic [3:0] S_TCUR     = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q, state_d;
	logic [pts_pkg::ACT_W-1:0] act_q, act_d;
	logic [SW-1:0] id_q, id_d;
	logic id_ok_q, id_ok_d;
	logic [pts_pkg::LVL_W-1:0] lvl_q, lvl_d;
	logic [pts_pkg::DUR_W-1:0] dur_q, dur_d;
	logic [SW-1:0] before_q, before_d;
	logic [pts_pkg::STAT_W-1:0] st_q, st_d;
	logic [CW-1:0] made_q, made_d;
	logic [pts_pkg::STAMP_W-1:0] stamp_q, stamp_d;
	logic [pts_pkg::WAKE_W-1:0] tick_q, tick_d;
	logic [SW-1:0] cur_q, cur_d;
	logic [pts_pkg::SLICE_W-1:0] slice_q, slice_d;
	logic [CW-1:0] nfree_q, nfree_d;
	logic [pts_pkg::SLICE_W-1:0] slice_ticks_q;
	logic preempt_q, sched_en_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic vld_s1, vld_d;
	logic [SW-1:0] idx_s1, idx_d;
	logic found_q, found_d;
	logic [SW-1:0] best_q, best_d;
	logic [pts_pkg::LVL_W-1:0] best_lvl_q, best_lvl_d;
	logic [pts_pkg::STAMP_W-1:0] best_age_q, best_age_d;
	logic out_valid_q;
	logic [pts_pkg::ID_W-1:0] out_run_q, out_new_q;
	logic out_sw_q;
	logic [pts_pkg::STAT_W-1:0] out_st_q;

	logic rd_en;
	logic [SW-1:0] rd_addr, wr_addr;
	pts_pkg::entry_t rd;
	pts_pkg::wreq_t wr;

	logic [7:0] id_ext;
	logic [8:0] cur_ext, made_ext;
	logic [pts_pkg::COND_W-1:0] tc;
	logic [pts_pkg::STAMP_W-1:0] age;
	logic [pts_pkg::WAKE_W-1:0] due_diff;
	logic [pts_pkg::SLICE_W-1:0] slice_dec;
	logic accept;

	pts_table #(.MAX_TASKS(MAX_TASKS), .SW(SW)) u_table (
		.clk(clk), .arst_n(arst_n), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd),
		.wr_addr(wr_addr), .wr(wr)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign id_ext = 8'(in_ch.task_id);
	assign cur_ext = 9'(cur_q);
	assign made_ext = 9'(made_q);
	assign tc = id_ok_q ? rd.cond : pts_pkg::C_FREE;
	assign age = stamp_q - rd.stamp;
	assign due_diff = tick_q - rd.wake;
	assign slice_dec = (slice_q != '0) ? slice_q - 8'd1 : '0;

	assign out_ch.valid = out_valid_q;
	assign out_ch.running_task = out_run_q;
	assign out_ch.switched = out_sw_q;
	assign out_ch.status = out_st_q;
	assign out_ch.new_task = out_new_q;

	always_comb begin
		state_d = state_q; act_d = act_q; id_d = id_q; id_ok_d = id_ok_q; lvl_d = lvl_q;
		dur_d = dur_q; before_d = before_q; st_d = st_q; made_d = made_q;
		stamp_d = stamp_q; tick_d = tick_q; cur_d = cur_q; slice_d = slice_q;
		nfree_d = nfree_q; cnt_d = cnt_q; vld_d = 1'b0; idx_d = idx_s1;
		found_d = found_q; best_d = best_q; best_lvl_d = best_lvl_q; best_age_d = best_age_q;
		rd_en = 1'b0; rd_addr = cur_q; wr = '0; wr_addr = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					act_d = in_ch.action;
					id_d = id_ext[SW-1:0];
					id_ok_d = 9'(id_ext) < 9'(MAX_TASKS);
					lvl_d = (4'(in_ch.priority_req) >= 4'(PRIORITY_LEVELS)) ? DEF_LVL :
						pts_pkg::LVL_W'(in_ch.priority_req);
					dur_d = in_ch.duration;
					before_d = cur_q;
					st_d = pts_pkg::ST_OK;
					made_d = '0;
					rd_en = 1'b1;
					rd_addr = (in_ch.action == pts_pkg::ACT_SLEEP) ? cur_q : id_ext[SW-1:0];
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_DONE;
				unique case (act_q)
					pts_pkg::ACT_CREATE: begin
						if (nfree_q >= CNT_MAX) begin
							st_d = pts_pkg::ST_FULL;
						end else begin
							wr.en = 1'b1; wr.cond = pts_pkg::C_READY;
							wr.lvl_en = 1'b1; wr.level = lvl_q;
							wr.stamp_en = 1'b1; wr.stamp = stamp_q;
							wr_addr = nfree_q[SW-1:0];
							stamp_d = stamp_q + 16'd1;
							made_d = nfree_q;
							nfree_d = nfree_q + CW'(1);
						end
					end
					pts_pkg::ACT_TERMINATE, pts_pkg::ACT_BLOCK: begin
						if (!id_ok_q || id_q == '0 || tc == pts_pkg::C_FREE ||
							tc == pts_pkg::C_TERMINATED ||
							(act_q == pts_pkg::ACT_BLOCK && tc == pts_pkg::C_BLOCKED)) begin
							st_d = pts_pkg::ST_INVALID;
						end else begin
							wr.en = 1'b1;
							wr.cond = (act_q == pts_pkg::ACT_BLOCK) ? pts_pkg::C_BLOCKED :
								pts_pkg::C_TERMINATED;
							wr_addr = id_q;
							if (id_q == cur_q) begin
								state_d = S_SCHED;
							end
						end
					end
					pts_pkg::ACT_TICK: begin
						tick_d = tick_q + 32'd1;
						cnt_d = '0; found_d = 1'b0;
						state_d = S_WSCAN;
					end
					pts_pkg::ACT_YIELD: begin
						state_d = S_SCHED;
					end
					pts_pkg::ACT_SLEEP: begin
						if (cur_q == '0 || rd.cond != pts_pkg::C_RUNNING) begin
							st_d = pts_pkg::ST_INVALID;
						end else begin
							wr.en = 1'b1; wr.cond = pts_pkg::C_SLEEPING;
							wr.stamp_en = 1'b1; wr.stamp = stamp_q;
							wr.wake_en = 1'b1; wr.wake = tick_q + 32'(dur_q);
							wr_addr = cur_q;
							stamp_d = stamp_q + 16'd1;
							state_d = S_SCHED;
						end
					end
					default: begin
						if (tc != ((act_q == pts_pkg::ACT_WAKE) ? pts_pkg::C_SLEEPING :
							pts_pkg::C_BLOCKED)) begin
							st_d = pts_pkg::ST_INVALID;
						end else begin
							wr.en = 1'b1; wr.cond = pts_pkg::C_READY;
							wr.stamp_en = 1'b1; wr.stamp = stamp_q;
							wr_addr = id_q;
							stamp_d = stamp_q + 16'd1;
						end
					end
				endcase
			end
			S_SCHED: begin
				if (!sched_en_q) begin
					state_d = S_DONE;
				end else begin
					rd_en = 1'b1; rd_addr = cur_q;
					state_d = S_SCHED_RD;
				end
			end
			S_SCHED_RD: begin
				if (rd.cond == pts_pkg::C_RUNNING) begin
					wr.en = 1'b1; wr.cond = pts_pkg::C_READY;
					wr.stamp_en = 1'b1; wr.stamp = stamp_q;
					wr_addr = cur_q;
					stamp_d = stamp_q + 16'd1;
				end
				cnt_d = '0; found_d = 1'b0;
				state_d = S_PSCAN;
			end
			S_PSCAN, S_WSCAN: begin
				if (vld_s1) begin
					if (state_q == S_PSCAN) begin
						if (rd.cond == pts_pkg::C_READY && (!found_q || rd.level > best_lvl_q ||
							(rd.level == best_lvl_q && age > best_age_q))) begin
							found_d = 1'b1; best_d = idx_s1;
							best_lvl_d = rd.level; best_age_d = age;
						end
					end else begin
						if (rd.cond == pts_pkg::C_SLEEPING && !due_diff[31] &&
							(!found_q || age > best_age_q)) begin
							found_d = 1'b1; best_d = idx_s1; best_age_d = age;
						end
					end
				end
				if (cnt_q < CNT_MAX) begin
					rd_en = 1'b1; rd_addr = cnt_q[SW-1:0];
					vld_d = 1'b1; idx_d = cnt_q[SW-1:0];
					cnt_d = cnt_q + CW'(1);
				end else begin
					state_d = (state_q == S_PSCAN) ? S_PEND : S_WEND;
				end
			end
			S_PEND: begin
				wr.en = 1'b1; wr.cond = pts_pkg::C_RUNNING;
				wr_addr = found_q ? best_q : '0;
				if (wr_addr != cur_q) begin
					cur_d = wr_addr;
					slice_d = slice_ticks_q;
				end
				state_d = S_DONE;
			end
			S_WEND: begin
				if (found_q) begin
					wr.en = 1'b1; wr.cond = pts_pkg::C_READY;
					wr.stamp_en = 1'b1; wr.stamp = stamp_q;
					wr_addr = best_q;
					stamp_d = stamp_q + 16'd1;
					cnt_d = '0; found_d = 1'b0;
					state_d = S_WSCAN;
				end else begin
					rd_en = 1'b1; rd_addr = cur_q;
					state_d = S_TCUR;
				end
			end
			S_TCUR: begin
				state_d = S_DONE;
				if (preempt_q && cur_q != '0 && rd.cond == pts_pkg::C_RUNNING) begin
					slice_d = slice_dec;
					if (slice_dec == '0) begin
						state_d = S_SCHED;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stamp_q <= '0;
			tick_q <= '0;
			cur_q <= '0;
			slice_q <= pts_pkg::SLICE_RESET;
			nfree_q <= CW'(1);
			slice_ticks_q <= pts_pkg::SLICE_RESET;
			preempt_q <= 1'b1;
			sched_en_q <= 1'b1;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stamp_q <= stamp_d;
			tick_q <= tick_d;
			cur_q <= cur_d;
			slice_q <= slice_d;
			nfree_q <= nfree_d;
			vld_s1 <= vld_d;
			found_q <= found_d;
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					pts_pkg::REG_SLICE: slice_ticks_q <= cfg_ch.data;
					pts_pkg::REG_PREEMPT: preempt_q <= cfg_ch.data[0];
					pts_pkg::REG_SCHED: sched_en_q <= cfg_ch.data[0];
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_q <= act_d; id_q <= id_d; id_ok_q <= id_ok_d; lvl_q <= lvl_d; dur_q <= dur_d;
		before_q <= before_d; st_q <= st_d; made_q <= made_d; cnt_q <= cnt_d;
		idx_s1 <= idx_d; best_q <= best_d; best_lvl_q <= best_lvl_d; best_age_q <= best_age_d;
		if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_run_q <= cur_ext[3:0];
			out_sw_q <= (cur_q != before_q);
			out_st_q <= st_q;
			out_new_q <= made_ext[3:0];
		end
	end

`ifndef SYNTHESIS
	a_nfree_range: assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q <= CNT_MAX) else $error("Free slot counter beyond table.");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE) else $error("Sequencer did not start on a transfer.");
	a_full_create: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q == pts_pkg::ST_FULL) |-> act_q == pts_pkg::ACT_CREATE)
		else $error("Table full reported for an action other than create.");
	a_made_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && made_q != '0) |-> st_q == pts_pkg::ST_OK)
		else $error("New slot reported on a failed action.");
`endif

endmodule

### rtl/pts_table.sv
// Task table memory with one registered read port and one masked write port.
module pts_table #(
	parameter int MAX_TASKS = 16,
	parameter int SW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [SW-1:0]        rd_addr,
	output pts_pkg::entry_t      rd_data,
	input  logic [SW-1:0]        wr_addr,
	input  pts_pkg::wreq_t       wr
);

	pts_pkg::entry_t mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] vld_q;
	pts_pkg::entry_t rst_entry;

	always_comb begin
		rst_entry = '0;
		rst_entry.cond = (rd_addr == '0) ? pts_pkg::C_RUNNING : pts_pkg::C_FREE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr].cond <= wr.cond;
			if (wr.lvl_en) begin
				mem[wr_addr].level <= wr.level;
			end else if (!vld_q[wr_addr]) begin
				mem[wr_addr].level <= '0;
			end
			if (wr.stamp_en) begin
				mem[wr_addr].stamp <= wr.stamp;
			end
			if (wr.wake_en) begin
				mem[wr_addr].wake <= wr.wake;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= vld_q[rd_addr] ? mem[rd_addr] : rst_entry;
		end
	end

endmodule
